// ===== rtl/graph_path_search_dfs_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the depth-first path search block
// Concurrent checks, clocked and reset-qualified; ASSERT_OFF empties them.
// ----------------------------------------------------------------------------
`ifndef GRAPH_PATH_SEARCH_DFS_TOP_ASSERT_SVH
`define GRAPH_PATH_SEARCH_DFS_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Plain property, checked at every clock edge out of reset
`define GPSD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gpsd assertion failed");
// Same-cycle implication
`define GPSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpsd assertion failed");
// Next-cycle implication
`define GPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpsd assertion failed");
`else
`define GPSD_ASSERT(label, clk, rst_n, prop)
`define GPSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/gpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// gpsd_pkg
// Shared constants and types of the depth-first path search block.
// ----------------------------------------------------------------------------
package gpsd_pkg;

    // Default vertex count of the adjacency matrix
    localparam int unsigned VERTICES_DEF = 16;

    // Width of every vertex field on the channels
    localparam int unsigned VTX_W = 4;

    // Input item kinds
    typedef enum logic
    {
        ACT_EDGE_WRITE = 1'b0,
        ACT_PATH_QUERY = 1'b1
    } action_t;

    // Sequencer states
    typedef enum logic [3:0]
    {
        S_IDLE,
        S_WR_MOD,
        S_ROW,
        S_POP,
        S_EMIT_END,
        S_EMIT,
        S_EMIT_NF,
        S_EMIT_ONE
    } state_t;

endpackage

// ===== rtl/gpsd_req_if.sv =====
// ----------------------------------------------------------------------------
// gpsd_req_if
// Input channel: edge writes and path queries, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gpsd_req_if;
    import gpsd_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [VTX_W-1:0]   edge_from;
    logic [VTX_W-1:0]   edge_to;
    logic               edge_present;
    logic [VTX_W-1:0]   start_vertex;
    logic [VTX_W-1:0]   end_vertex;

    modport source
    (
        output valid, action, edge_from, edge_to, edge_present, start_vertex, end_vertex,
        input  ready
    );

    modport sink
    (
        input  valid, action, edge_from, edge_to, edge_present, start_vertex, end_vertex,
        output ready
    );

endinterface

// ----------------------------------------------------------------------------
// gpsd_rsp_if
// Result channel: path vertices end first, or one not-found result.
// ----------------------------------------------------------------------------
interface gpsd_rsp_if;
    import gpsd_pkg::*;

    logic               valid;
    logic               ready;
    logic               path_found;
    logic [VTX_W-1:0]   path_vertex;
    logic               last;

    modport source
    (
        output valid, path_found, path_vertex, last,
        input  ready
    );

    modport sink
    (
        input  valid, path_found, path_vertex, last,
        output ready
    );

endinterface

// ===== rtl/gpsd_ram.sv =====
// ----------------------------------------------------------------------------
// gpsd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gpsd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/gpsd_ffs.sv =====
// ----------------------------------------------------------------------------
// gpsd_ffs
// Find-first-set unit: index of the lowest set bit of a candidate mask.
// ----------------------------------------------------------------------------
module gpsd_ffs #(
    parameter int unsigned WIDTH = 16
) (
    input  logic [WIDTH-1:0]         bits,
    output logic                     found,
    output logic [$clog2(WIDTH)-1:0] index
);

    localparam int unsigned IW = $clog2(WIDTH);

    logic [WIDTH-1:0] lowest;

    // Isolate the lowest set bit
    assign lowest = bits & (~bits + WIDTH'(1));
    assign found  = |bits;

    // One-hot to binary: each index bit ORs the lanes that carry it
    always_comb
    begin
        logic [IW-1:0] acc;
        acc = '0;
        for (int b = 0; b < IW; b++)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    acc[b] = acc[b] | lowest[i];
                end
            end
        end
        index = acc;
    end

endmodule

// ===== rtl/graph_path_search_dfs_top.sv =====
// ----------------------------------------------------------------------------
// graph_path_search_dfs_top
// Depth-first path search over a directed adjacency matrix held in RAM.
//
//   channel  dir  payload                                              transfer
//   req      in   action edge_from edge_to edge_present start end      valid & ready
//   rsp      out  path_found path_vertex last                          valid & ready
//
// Edge write: row read, then row write. Query: accept, then per step either a
// forward move (S_ROW) or a backtrack (S_ROW, then S_POP for the registered
// stack RAM read), then the end hit and each path vertex, or, for not-found,
// the last dead end and the result; result stalls can hold the emission.
// The pace is set by the single find-first unit and the one read port of each RAM.
// Adjacency rows carry valid bits cleared at reset: an unwritten row reads zero.
// A full result register stalls emission only; req.ready is high in idle.
// ----------------------------------------------------------------------------
`include "graph_path_search_dfs_top_assert.svh"

module graph_path_search_dfs_top #(
    parameter int unsigned VERTICES = gpsd_pkg::VERTICES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    gpsd_req_if.sink    req,
    gpsd_rsp_if.source  rsp
);
    import gpsd_pkg::*;

    localparam int unsigned VW = $clog2(VERTICES);
    localparam int unsigned DW = $clog2(VERTICES + 1);
    localparam logic [VERTICES-1:0] ONE_HOT0 = VERTICES'(1);

    state_t              state_reg, state_next;
    logic [VERTICES-1:0] visited_reg, visited_next;
    logic [VERTICES-1:0] adj_valid_reg, adj_valid_next;
    logic                row_valid_reg;
    logic [VW-1:0]       cur_reg, cur_next;
    logic [VW-1:0]       end_reg, end_next;
    logic [VW-1:0]       from_reg, from_next;
    logic [VW-1:0]       to_reg, to_next;
    logic                present_reg, present_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [DW-1:0]       depth_m1, depth_m2;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic [VTX_W-1:0]    out_vertex_reg, out_vertex_next;
    logic                out_last_reg, out_last_next;
    logic                out_load, slot_free;

    // Adjacency RAM
    logic                adj_rd_en, adj_wr_en;
    logic [VW-1:0]       adj_rd_addr, adj_wr_addr;
    logic [VERTICES-1:0] adj_rd_data, adj_wr_data;

    // Stack RAM
    logic                stk_rd_en, stk_wr_en;
    logic [VW-1:0]       stk_rd_addr, stk_wr_addr, stk_wr_data, stk_rd_data;

    // Search datapath
    logic [VERTICES-1:0] row, cand;
    logic                ff_found;
    logic [VW-1:0]       ff_index;
    logic [VW-1:0]       req_from, req_to, req_start, req_end;
    logic                from_ok, to_ok, start_ok, end_ok;

    gpsd_ram #(
        .WIDTH (VERTICES),
        .DEPTH (VERTICES)
    ) u_adj_ram (
        .clk     (clk),
        .wr_en   (adj_wr_en),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data),
        .rd_en   (adj_rd_en),
        .rd_addr (adj_rd_addr),
        .rd_data (adj_rd_data)
    );

    gpsd_ram #(
        .WIDTH (VW),
        .DEPTH (VERTICES)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // Row of the current top vertex, minus vertices already visited
    assign row  = row_valid_reg ? adj_rd_data : '0;
    assign cand = row & ~visited_reg;

    gpsd_ffs #(
        .WIDTH (VERTICES)
    ) u_ffs (
        .bits  (cand),
        .found (ff_found),
        .index (ff_index)
    );

    // Input field ranges and indexes
    assign from_ok   = 32'(req.edge_from) < VERTICES;
    assign to_ok     = 32'(req.edge_to) < VERTICES;
    assign start_ok  = 32'(req.start_vertex) < VERTICES;
    assign end_ok    = 32'(req.end_vertex) < VERTICES;
    assign req_from  = VW'(req.edge_from);
    assign req_to    = VW'(req.edge_to);
    assign req_start = VW'(req.start_vertex);
    assign req_end   = VW'(req.end_vertex);

    assign depth_m1  = depth_reg - DW'(1);
    assign depth_m2  = depth_reg - DW'(2);
    assign slot_free = !out_valid_reg || rsp.ready;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        visited_next    = visited_reg;
        adj_valid_next  = adj_valid_reg;
        cur_next        = cur_reg;
        end_next        = end_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        present_next    = present_reg;
        depth_next      = depth_reg;
        req.ready       = 1'b0;
        adj_rd_en       = 1'b0;
        adj_rd_addr     = cur_reg;
        adj_wr_en       = 1'b0;
        adj_wr_addr     = from_reg;
        adj_wr_data     = row;
        stk_rd_en       = 1'b0;
        stk_rd_addr     = depth_m1[VW-1:0];
        stk_wr_en       = 1'b0;
        stk_wr_addr     = depth_reg[VW-1:0];
        stk_wr_data     = ff_index;
        out_load        = 1'b0;
        out_found_next  = 1'b0;
        out_vertex_next = '0;
        out_last_next   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (req.action == ACT_EDGE_WRITE)
                    begin
                        // Out-of-range entries are dropped
                        if (from_ok && to_ok)
                        begin
                            from_next    = req_from;
                            to_next      = req_to;
                            present_next = req.edge_present;
                            adj_rd_en    = 1'b1;
                            adj_rd_addr  = req_from;
                            state_next   = S_WR_MOD;
                        end
                    end
                    else
                    begin
                        visited_next = '0;
                        depth_next   = '0;
                        end_next     = req_end;
                        cur_next     = req_start;
                        if (!start_ok || !end_ok)
                        begin
                            state_next = S_EMIT_NF;
                        end
                        else if (req.start_vertex == req.end_vertex)
                        begin
                            state_next = S_EMIT_ONE;
                        end
                        else
                        begin
                            // Push the start vertex and fetch its row
                            stk_wr_en    = 1'b1;
                            stk_wr_addr  = '0;
                            stk_wr_data  = req_start;
                            depth_next   = DW'(1);
                            visited_next = ONE_HOT0 << req_start;
                            adj_rd_en    = 1'b1;
                            adj_rd_addr  = req_start;
                            state_next   = S_ROW;
                        end
                    end
                end
            end

            S_WR_MOD:
            begin
                // Read-modify-write of one adjacency bit
                adj_wr_en               = 1'b1;
                adj_wr_data[to_reg]     = present_reg;
                adj_valid_next[from_reg] = 1'b1;
                state_next              = S_IDLE;
            end

            S_ROW:
            begin
                if (!ff_found)
                begin
                    // Dead end: backtrack
                    depth_next = depth_m1;
                    if (depth_m1 == '0)
                    begin
                        state_next = S_EMIT_NF;
                    end
                    else
                    begin
                        stk_rd_en   = 1'b1;
                        stk_rd_addr = depth_m2[VW-1:0];
                        state_next  = S_POP;
                    end
                end
                else if (ff_index == end_reg)
                begin
                    state_next = S_EMIT_END;
                end
                else
                begin
                    // Step forward to the first unvisited neighbor
                    visited_next = visited_reg | (ONE_HOT0 << ff_index);
                    adj_rd_en    = 1'b1;
                    if (depth_reg < DW'(VERTICES))
                    begin
                        stk_wr_en   = 1'b1;
                        depth_next  = depth_reg + DW'(1);
                        cur_next    = ff_index;
                        adj_rd_addr = ff_index;
                    end
                end
            end

            S_POP:
            begin
                cur_next    = stk_rd_data;
                adj_rd_en   = 1'b1;
                adj_rd_addr = stk_rd_data;
                state_next  = S_ROW;
            end

            S_EMIT_END:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_found_next  = 1'b1;
                    out_vertex_next = VTX_W'(end_reg);
                    stk_rd_en       = 1'b1;
                    state_next      = S_EMIT;
                end
            end

            S_EMIT:
            begin
                // Pop the path, top of stack first
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_found_next  = 1'b1;
                    out_vertex_next = VTX_W'(stk_rd_data);
                    out_last_next   = (depth_reg == DW'(1));
                    depth_next      = depth_m1;
                    if (depth_reg == DW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        stk_rd_en   = 1'b1;
                        stk_rd_addr = depth_m2[VW-1:0];
                    end
                end
            end

            S_EMIT_NF:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    depth_next    = '0;
                    state_next    = S_IDLE;
                end
            end

            S_EMIT_ONE:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_found_next  = 1'b1;
                    out_vertex_next = VTX_W'(cur_reg);
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            visited_reg   <= '0;
            adj_valid_reg <= '0;
            row_valid_reg <= 1'b0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            visited_reg   <= visited_next;
            adj_valid_reg <= adj_valid_next;
            if (adj_rd_en)
            begin
                row_valid_reg <= adj_valid_reg[adj_rd_addr];
            end
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        end_reg     <= end_next;
        from_reg    <= from_next;
        to_reg      <= to_next;
        present_reg <= present_next;
        if (out_load)
        begin
            out_found_reg  <= out_found_next;
            out_vertex_reg <= out_vertex_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.path_found  = out_found_reg;
    assign rsp.path_vertex = out_vertex_reg;
    assign rsp.last        = out_last_reg;

    // Checks
    `GPSD_ASSERT(a_depth_bound, clk, rst_n, depth_reg <= DW'(VERTICES))
    `GPSD_ASSERT_IMPLY(a_top_visited, clk, rst_n, state_reg == S_ROW, depth_reg != '0 && visited_reg[cur_reg])
    `GPSD_ASSERT_IMPLY(a_ffs_hit, clk, rst_n, state_reg == S_ROW && ff_found, row[ff_index] && !visited_reg[ff_index])
    `GPSD_ASSERT_NEXT(a_last_idle, clk, rst_n, out_load && out_last_next, state_reg == S_IDLE && depth_reg == '0)

endmodule

// ===== bench/graph_path_search_dfs_top_tb.sv =====
// ----------------------------------------------------------------------------
// graph_path_search_dfs_top_tb
// Self-checking bench for the depth-first path search block. Edge writes and
// path queries go in over the request channel. A scoreboard keeps its own
// adjacency matrix, reruns each search and checks every result transfer in
// order. Both channels idle at random. The result side holds off once for a
// long stretch so the block backs up into its request channel.
// ----------------------------------------------------------------------------
module graph_path_search_dfs_top_tb;
    import gpsd_pkg::*;

    localparam int NV           = VERTICES_DEF;
    localparam int ITEM_TARGET  = 370;
    localparam int QUIET_AFTER  = 300;
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int EDGE_CAP     = 48;

    typedef logic [VTX_W-1:0] vtx_t;

    typedef struct packed
    {
        logic path_found;
        vtx_t path_vertex;
        logic last;
    } path_beat_t;

    typedef struct packed
    {
        action_t action;
        vtx_t    edge_from;
        vtx_t    edge_to;
        logic    edge_present;
        vtx_t    start_vertex;
        vtx_t    end_vertex;
    } graph_req_t;

    // Scoreboard: mirrored adjacency matrix and queue of path vertices due
    class path_scoreboard;
        logic [NV-1:0] adj_rows [NV];
        path_beat_t    path_due [$];
        int            miss_count;

        function new();
            foreach (adj_rows[r])
                adj_rows[r] = '0;
            miss_count = 0;
        endfunction

        // DFS, ascending neighbor order, marks kept across backtracking
        function void search_path(vtx_t src, vtx_t dst);
            vtx_t        trail_vtx  [NV];
            int          trail_next [NV];
            logic [NV-1:0] seen;
            int          depth;
            int          n;
            vtx_t        cur;
            if (src == dst)
            begin
                path_due.push_back(path_beat_t'{1'b1, src, 1'b1});
                return;
            end
            trail_vtx[0]  = src;
            trail_next[0] = 0;
            depth         = 1;
            seen          = '0;
            seen[src]     = 1'b1;
            while (depth > 0)
            begin
                cur = trail_vtx[depth-1];
                n   = trail_next[depth-1];
                while (n < NV && !(adj_rows[cur][n] && !seen[n]))
                    n++;
                if (n >= NV)
                begin
                    depth--;
                    continue;
                end
                trail_next[depth-1] = n + 1;
                if (n == int'(dst))
                begin
                    // path goes out end first, start last
                    path_due.push_back(path_beat_t'{1'b1, dst, 1'b0});
                    while (depth > 0)
                    begin
                        depth--;
                        path_due.push_back(path_beat_t'{1'b1, trail_vtx[depth],
                                                        depth == 0});
                    end
                    return;
                end
                if (depth < NV)
                begin
                    trail_vtx[depth]  = vtx_t'(n);
                    trail_next[depth] = 0;
                    depth++;
                end
                seen[n] = 1'b1;
            end
            path_due.push_back(path_beat_t'{1'b0, vtx_t'(0), 1'b1});
        endfunction

        function void note_request(graph_req_t item);
            if (item.action == ACT_EDGE_WRITE)
                adj_rows[item.edge_from][item.edge_to] = item.edge_present;
            else
                search_path(item.start_vertex, item.end_vertex);
        endfunction

        function void check_result(path_beat_t got);
            path_beat_t want;
            if (path_due.size() == 0)
            begin
                miss_count++;
                if (miss_count <= 10)
                    $display("[%0t] unexpected result: found=%0b vertex=%0d last=%0b",
                             $time, got.path_found, got.path_vertex, got.last);
                return;
            end
            want = path_due.pop_front();
            if (got.path_found !== want.path_found || got.path_vertex !== want.path_vertex
                || got.last !== want.last)
            begin
                miss_count++;
                if (miss_count <= 10)
                    $display("[%0t] mismatch: expected found=%0b vertex=%0d last=%0b, %s%0b %s%0d %s%0b",
                             $time, want.path_found, want.path_vertex, want.last,
                             "got found=", got.path_found, "vertex=", got.path_vertex,
                             "last=", got.last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   items_sent = 0;

    path_scoreboard scoreboard;

    gpsd_req_if req_ch();
    gpsd_rsp_if rsp_ch();

    graph_path_search_dfs_top u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // One request transfer, with an occasional idle burst ahead of it
    task automatic send_item(graph_req_t item);
        if (items_sent < QUIET_AFTER && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= item.action;
        req_ch.edge_from    <= item.edge_from;
        req_ch.edge_to      <= item.edge_to;
        req_ch.edge_present <= item.edge_present;
        req_ch.start_vertex <= item.start_vertex;
        req_ch.end_vertex   <= item.end_vertex;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        scoreboard.note_request(item);
        items_sent++;
    endtask

    // Unused fields carry random values
    task automatic write_edge(vtx_t from_v, vtx_t to_v, logic present);
        graph_req_t item;
        item.action       = ACT_EDGE_WRITE;
        item.edge_from    = from_v;
        item.edge_to      = to_v;
        item.edge_present = present;
        item.start_vertex = vtx_t'($urandom);
        item.end_vertex   = vtx_t'($urandom);
        send_item(item);
    endtask

    task automatic query_path(vtx_t src, vtx_t dst);
        graph_req_t item;
        item.action       = ACT_PATH_QUERY;
        item.edge_from    = vtx_t'($urandom);
        item.edge_to      = vtx_t'($urandom);
        item.edge_present = 1'($urandom_range(0, 1));
        item.start_vertex = src;
        item.end_vertex   = dst;
        send_item(item);
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            scoreboard.check_result(path_beat_t'{rsp_ch.path_found, rsp_ch.path_vertex,
                                                 rsp_ch.last});
    end

    // Result side: random stall bursts, one long hold-off, none near the end
    initial
    begin : result_sink
        bit held_once;
        held_once = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (!held_once && items_sent >= HOLD_AFTER)
            begin
                // block fills up and has to drop req.ready
                held_once = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (items_sent < QUIET_AFTER && $urandom_range(0, 11) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Run limit
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("graph_path_search_dfs_top_tb NOT OK");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        vtx_t order [NV];
        vtx_t swap_v;
        int   span;
        int   gap_at;
        int   pick;
        int   j;
        int   edges_now;
        scoreboard = new();
        foreach (order[i])
            order[i] = vtx_t'(i);
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.action       <= ACT_EDGE_WRITE;
        req_ch.edge_from    <= '0;
        req_ch.edge_to      <= '0;
        req_ch.edge_present <= 1'b0;
        req_ch.start_vertex <= '0;
        req_ch.end_vertex   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: start equals end, empty graph, single edge set and cleared
        query_path(vtx_t'(0), vtx_t'(0));
        query_path(vtx_t'(0), vtx_t'(NV-1));
        write_edge(vtx_t'(NV-1), vtx_t'(0), 1'b1);
        query_path(vtx_t'(NV-1), vtx_t'(0));
        write_edge(vtx_t'(NV-1), vtx_t'(0), 1'b0);
        query_path(vtx_t'(NV-1), vtx_t'(0));

        // Directed: full-length chain, longest path
        for (int v = 0; v < NV-1; v++)
            write_edge(vtx_t'(v), vtx_t'(v+1), 1'b1);
        query_path(vtx_t'(0), vtx_t'(NV-1));
        query_path(vtx_t'(NV-1), vtx_t'(NV-1));
        query_path(vtx_t'(NV-1), vtx_t'(0));

        // Random episodes
        while (items_sent < ITEM_TARGET)
        begin
            pick      = $urandom_range(0, 9);
            edges_now = 0;
            for (int r = 0; r < NV; r++)
                edges_now += $countones(scoreboard.adj_rows[r]);
            if (edges_now > EDGE_CAP)
            begin
                // too dense: clear every edge so chains steer the search again
                for (int r = 0; r < NV; r++)
                    for (int c = 0; c < NV; c++)
                        if (scoreboard.adj_rows[r][c])
                            write_edge(vtx_t'(r), vtx_t'(c), 1'b0);
            end
            else if (pick < 6)
            begin
                // chain through a shuffled vertex order, sometimes one link short
                for (int i = NV-1; i > 0; i--)
                begin
                    j        = $urandom_range(0, i);
                    swap_v   = order[i];
                    order[i] = order[j];
                    order[j] = swap_v;
                end
                span   = $urandom_range(2, NV);
                gap_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span-2) : -1;
                for (int i = 0; i < span-1; i++)
                    if (i != gap_at)
                        write_edge(order[i], order[i+1], 1'b1);
                query_path(order[0], order[span-1]);
                repeat ($urandom_range(0, 3))
                    query_path(order[$urandom_range(0, span-1)],
                               order[$urandom_range(0, span-1)]);
                // tear the chain down half the time
                if ($urandom_range(0, 1) == 1)
                    for (int i = 0; i < span-1; i++)
                        write_edge(order[i], order[i+1], 1'b0);
            end
            else if (pick < 8)
            begin
                // edge noise, set and clear
                repeat ($urandom_range(1, 6))
                    write_edge(vtx_t'($urandom), vtx_t'($urandom),
                               1'($urandom_range(0, 1)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    query_path(vtx_t'($urandom), vtx_t'($urandom));
            end
        end

        // Drain
        req_ch.valid <= 1'b0;
        while (scoreboard.path_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (scoreboard.miss_count == 0 && scoreboard.path_due.size() == 0)
            $display("graph_path_search_dfs_top_tb OK");
        else
            $display("graph_path_search_dfs_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gpsd_pkg.sv
rtl/gpsd_req_if.sv
rtl/gpsd_ram.sv
rtl/gpsd_ffs.sv
rtl/graph_path_search_dfs_top.sv
bench/graph_path_search_dfs_top_tb.sv
